### design/sum_mean_stddev_accumulator_top_defines.svh
// Assertion macros shared by the checker of the set statistics accumulator.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef SUM_MEAN_STDDEV_ACCUMULATOR_TOP_DEFINES_SVH
`define SUM_MEAN_STDDEV_ACCUMULATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent, outside reset.
`define SMSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smsa checker: property failed");

// Consequent checked in the cycle after the antecedent, outside reset.
`define SMSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smsa checker: property failed");

// Consequent checked in the cycle that follows a reset cycle.
`define SMSA_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("smsa checker: property failed");

`endif

### design/smsa_pkg.sv
// Package of the set statistics accumulator: widths, step counts and the
// records passed between front end, queue and back end. No dependencies.
package smsa_pkg;

  localparam int SAMPLE_W   = 16;  // sample port
  localparam int N_W        = 17;  // item count of one set
  localparam int SUM_W      = 32;  // running sum, total port
  localparam int SQ_W       = 47;  // running sum of squares
  localparam int MAG_W      = 32;  // magnitude of the sum
  localparam int PROD_W     = 64;  // serial product accumulators
  localparam int DIFF_W     = 63;  // n*sumsq - sum^2
  localparam int SD_SHIFT   = 16;  // two times the fraction bits
  localparam int FRAC_BITS  = 8;
  localparam int DVD_W      = DIFF_W + SD_SHIFT;
  localparam int DVS_W      = 33;  // n^2 reaches 2^32
  localparam int MEAN_DVD_W = MAG_W + FRAC_BITS;
  localparam int MEAN_W     = 24;
  localparam int STD_W      = 23;
  localparam int ROOT_W     = 24;
  localparam int SQX_W      = 2 * ROOT_W;
  localparam int Q_DEPTH    = 2;
  localparam int STEP_W     = 7;

  localparam int MUL_STEPS  = MAG_W;
  localparam int SD_STEPS   = DVD_W;
  localparam int MEAN_STEPS = MEAN_DVD_W;
  localparam int SQRT_STEPS = ROOT_W;

  // One finished set as handed from the front end to the back end.
  typedef struct packed {
    logic [N_W-1:0]          n;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
  } set_t;

  // Queue fill status seen by the front end.
  typedef struct packed {
    logic full;
    logic one_left;
  } q_stat_t;

endpackage

### design/sum_mean_stddev_accumulator_top.sv
// Channel  Handshake            Fields
// request  start & !busy        sample, last
// result   done (one cycle)     total, mean_value, std_dev
//
// A sample is taken every cycle while busy is low; the front end accumulates it
// in the cycle after acceptance. The back end takes each set through load,
// serial products, subtract, the variance and mean divides, the root and
// output, one set at a time. busy rises when the two-entry set queue is
// or is about to be full. rst clears the accumulators, queue and sequencer.
// Each result is shown for one cycle with done high; the receiver cannot stall.
// Top level of the set statistics accumulator. Depends on smsa_pkg,
// smsa_front, smsa_queue and smsa_back.
module sum_mean_stddev_accumulator_top #(
  parameter int MAX_ITEMS   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [smsa_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  output logic                                 done,
  output logic signed [smsa_pkg::SUM_W-1:0]    total,
  output logic signed [smsa_pkg::MEAN_W-1:0]   mean_value,
  output logic [smsa_pkg::STD_W-1:0]           std_dev
);
  import smsa_pkg::*;

  logic    push;
  set_t    push_set;
  logic    pop;
  set_t    head;
  logic    head_valid;
  q_stat_t q_stat;

  smsa_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .sample  (sample),
    .last    (last),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push),
    .push_set(push_set)
  );

  smsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_set  (push_set),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .q_stat    (q_stat)
  );

  smsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .done      (done),
    .total     (total),
    .mean_value(mean_value),
    .std_dev   (std_dev)
  );

endmodule

### design/smsa_front.sv
// Front end: takes samples, keeps count, sum and sum of squares, and pushes
// a finished set into the queue. Depends on smsa_pkg.
module smsa_front #(
  parameter int MAX_ITEMS   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [smsa_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  input  smsa_pkg::q_stat_t                    q_stat,
  output logic                                 busy,
  output logic                                 push,
  output smsa_pkg::set_t                       push_set
);
  import smsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic                          stage_valid;
  logic                          stage_last;
  logic signed [SAMPLE_BITS-1:0] stage_s;
  logic signed [2*SAMPLE_BITS-1:0] square;
  logic [CNT_W-1:0]              count;
  logic signed [SUM_W-1:0]       sum;
  logic [SQ_W-1:0]               sumsq;
  logic [CNT_W-1:0]              count_next;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SQ_W-1:0]               sumsq_next;
  logic                          accept;
  logic                          add;

  // A set ending in the stage register still needs a queue slot.
  assign busy   = q_stat.full | (q_stat.one_left & stage_valid & stage_last);
  assign accept = start & ~busy;

  assign square = stage_s * stage_s;
  assign add    = stage_valid & (count < CNT_W'(MAX_ITEMS));

  always_comb begin
    count_next = count;
    sum_next   = sum;
    sumsq_next = sumsq;
    if (add) begin
      count_next = count + CNT_W'(1);
      sum_next   = sum + SUM_W'(stage_s);
      sumsq_next = sumsq + SQ_W'($unsigned(square));
    end
  end

  assign push           = stage_valid & stage_last;
  assign push_set.n     = N_W'(count_next);
  assign push_set.sum   = sum_next;
  assign push_set.sumsq = sumsq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      stage_last  <= 1'b0;
      count       <= '0;
      sum         <= '0;
      sumsq       <= '0;
    end else begin
      stage_valid <= accept;
      stage_last  <= accept & last;
      if (push) begin
        count <= '0;
        sum   <= '0;
        sumsq <= '0;
      end else begin
        count <= count_next;
        sum   <= sum_next;
        sumsq <= sumsq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_s <= sample[SAMPLE_BITS-1:0];
    end
  end

endmodule

### design/smsa_queue.sv
// Short queue of finished sets between the front end and the back end.
// Depends on smsa_pkg.
module smsa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  smsa_pkg::set_t    push_set,
  input  logic              pop,
  output smsa_pkg::set_t    head,
  output logic              head_valid,
  output smsa_pkg::q_stat_t q_stat
);
  import smsa_pkg::*;

  localparam int PTR_W  = $clog2(Q_DEPTH);
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  set_t              entries [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign head            = entries[rd_ptr];
  assign head_valid      = (fill != '0);
  assign q_stat.full     = (fill == FILL_W'(Q_DEPTH));
  assign q_stat.one_left = (fill == FILL_W'(Q_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_set;
    end
  end

endmodule

### design/smsa_back.sv
// Back end: per set, serial products, a restoring divider for variance and
// mean, and a digit-by-digit square root. Depends on smsa_pkg.
module smsa_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  smsa_pkg::set_t                         head,
  input  logic                                   head_valid,
  output logic                                   pop,
  output logic                                   done,
  output logic signed [smsa_pkg::SUM_W-1:0]      total,
  output logic signed [smsa_pkg::MEAN_W-1:0]     mean_value,
  output logic [smsa_pkg::STD_W-1:0]             std_dev
);
  import smsa_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_DIFF  = 7'b0000100,
    ST_DIVSD = 7'b0001000,
    ST_DIVM  = 7'b0010000,
    ST_SQRT  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t                   state;
  logic [STEP_W-1:0]        step;
  logic                     zero_n;
  logic                     neg;
  logic signed [SUM_W-1:0]  sum_r;
  logic [MAG_W-1:0]         mag_r;
  logic [N_W-1:0]           n_r;
  logic [MAG_W-1:0]         head_mag;

  logic [PROD_W-1:0]        a_mcand, a_acc, b_mcand, b_acc;
  logic [N_W-1:0]           a_mplier, c_mplier;
  logic [MAG_W-1:0]         b_mplier;
  logic [DVS_W-1:0]         c_mcand, c_acc;
  logic [PROD_W-1:0]        diff;

  logic [DVD_W-1:0]         dq;
  logic [DVS_W-1:0]         rem, dvs;
  logic [DVS_W:0]           dtry, dsub;
  logic                     dge;
  logic [DVS_W-1:0]         rem_step;
  logic [DVD_W-1:0]         dq_step;
  logic [MEAN_DVD_W-1:0]    quot_m, mean_full;

  logic [SQX_W-1:0]         sx;
  logic [ROOT_W+1:0]        srem;
  logic [ROOT_W-1:0]        root;
  logic [ROOT_W+3:0]        stry, strial, ssub;
  logic                     sge;

  logic signed [MEAN_W-1:0] mean_r;

  assign head_mag = head.sum[SUM_W-1] ? MAG_W'(-head.sum) : MAG_W'(head.sum);
  assign pop      = (state == ST_IDLE) && head_valid;
  assign diff     = a_acc - b_acc;

  // One restoring divide step: remainder gains the next dividend bit.
  assign dtry     = {rem, dq[DVD_W-1]};
  assign dsub     = dtry - {1'b0, dvs};
  assign dge      = (dtry >= {1'b0, dvs});
  assign rem_step = dge ? dsub[DVS_W-1:0] : dtry[DVS_W-1:0];
  assign dq_step  = {dq[DVD_W-2:0], dge};
  assign quot_m   = dq_step[MEAN_DVD_W-1:0];
  assign mean_full = neg ? (-quot_m) : quot_m;

  // One root step: bring down two bits, try root*4+1.
  assign stry   = {srem, sx[SQX_W-1 -: 2]};
  assign strial = (ROOT_W+4)'({root, 2'b01});
  assign ssub   = stry - strial;
  assign sge    = (stry >= strial);

  assign done       = (state == ST_OUT);
  assign total      = zero_n ? '0 : sum_r;
  assign mean_value = mean_r;
  assign std_dev    = zero_n ? '0 : root[STD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            n_r      <= head.n;
            sum_r    <= head.sum;
            neg      <= head.sum[SUM_W-1];
            mag_r    <= head_mag;
            zero_n   <= (head.n == '0);
            a_mcand  <= PROD_W'(head.sumsq);
            a_mplier <= head.n;
            a_acc    <= '0;
            b_mcand  <= PROD_W'(head_mag);
            b_mplier <= head_mag;
            b_acc    <= '0;
            c_mcand  <= DVS_W'(head.n);
            c_mplier <= head.n;
            c_acc    <= '0;
            step     <= '0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (a_mplier[0]) a_acc <= a_acc + a_mcand;
          if (b_mplier[0]) b_acc <= b_acc + b_mcand;
          if (c_mplier[0]) c_acc <= c_acc + c_mcand;
          a_mcand  <= a_mcand << 1;
          b_mcand  <= b_mcand << 1;
          c_mcand  <= c_mcand << 1;
          a_mplier <= a_mplier >> 1;
          b_mplier <= b_mplier >> 1;
          c_mplier <= c_mplier >> 1;
          step     <= step + STEP_W'(1);
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          // Scale by 2^16 so that the root carries 8 fraction bits.
          dq    <= {diff[DIFF_W-1:0], {SD_SHIFT{1'b0}}};
          rem   <= '0;
          dvs   <= c_acc;
          step  <= '0;
          state <= ST_DIVSD;
        end
        ST_DIVSD: begin
          if (step == STEP_W'(SD_STEPS - 1)) begin
            sx    <= {1'b0, dq_step[SQ_W-1:0]};
            dq    <= {mag_r, {FRAC_BITS{1'b0}}, {(DVD_W - MEAN_DVD_W){1'b0}}};
            rem   <= '0;
            dvs   <= DVS_W'(n_r);
            step  <= '0;
            state <= ST_DIVM;
          end else begin
            dq   <= dq_step;
            rem  <= rem_step;
            step <= step + STEP_W'(1);
          end
        end
        ST_DIVM: begin
          if (step == STEP_W'(MEAN_STEPS - 1)) begin
            mean_r <= zero_n ? '0 : $signed(mean_full[MEAN_W-1:0]);
            srem   <= '0;
            root   <= '0;
            step   <= '0;
            state  <= ST_SQRT;
          end else begin
            dq   <= dq_step;
            rem  <= rem_step;
            step <= step + STEP_W'(1);
          end
        end
        ST_SQRT: begin
          srem <= sge ? ssub[ROOT_W+1:0] : stry[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], sge};
          sx   <= sx << 2;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/smsa_checker.sv
// Port-level checker of the set statistics accumulator and its bind.
// Depends on smsa_pkg and the assertion macros header.
`include "sum_mean_stddev_accumulator_top_defines.svh"

module smsa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               busy,
  input logic                               done,
  input logic signed [smsa_pkg::SUM_W-1:0]  total,
  input logic signed [smsa_pkg::MEAN_W-1:0] mean_value
);
  import smsa_pkg::*;

  // Results are separated by a full back-end pass, so done never repeats.
  `SMSA_ASSERT_NEXT(a_done_single, done, !done)
  // A zero sum can only give a zero mean.
  `SMSA_ASSERT_SAME(a_zero_sum_mean, done && (total == '0), mean_value == '0)
  // A non-negative sum never gives a negative mean.
  `SMSA_ASSERT_SAME(a_mean_sign, done && !total[SUM_W-1], !mean_value[MEAN_W-1])
  // Reset leaves an empty queue and an idle back end.
  `SMSA_ASSERT_RESET(a_reset_quiet, !done && !busy)

endmodule

bind sum_mean_stddev_accumulator_top smsa_checker u_smsa_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .total     (total),
  .mean_value(mean_value)
);
